// ===== src/dwalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-word ALU package
// Opcodes, status codes, flag positions and the stage record type.
// ----------------------------------------------------------------------------
package dwalu_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam int FLAG_Z = 3;
    localparam int FLAG_M = 2;
    localparam int FLAG_V = 1;
    localparam int FLAG_C = 0;

    localparam int DIV_STAGES = 16;

    // One item in flight through the divider pipeline.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] reg_high;
        logic [15:0] reg_low;
        logic [3:0]  flags;
        logic [15:0] res_high;
        logic [15:0] res_low;
        logic [3:0]  res_flags;
        logic        a_neg;
        logic        d_neg;
        logic        div0;
        logic [31:0] rem;     // partial remainder / dividend shift word
        logic [15:0] dmag;    // divisor magnitude
        logic [15:0] quo;
        logic        qovf;    // unsigned quotient exceeded 16 bits
    } item_t;

endpackage

// ===== src/dwalu_div_stage.sv =====
// ----------------------------------------------------------------------------
// Double-word ALU divide stage
// One restoring division step on a registered item, with stall support.
// ----------------------------------------------------------------------------
module dwalu_div_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  dwalu_pkg::item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output dwalu_pkg::item_t out_item
);
    logic             valid_reg;
    dwalu_pkg::item_t item_reg;
    dwalu_pkg::item_t item_next;
    logic [16:0]      trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Remainder word holds rem[31:16] as partial remainder and rem[15:0]
    // as remaining dividend bits; the quotient overflow shows as a bit shifted out of quo[15].
    always_comb begin
        item_next = in_item;
        trial = {in_item.rem[31:15]} - {1'b0, in_item.dmag};
        if (!trial[16]) begin
            item_next.rem = {trial[15:0], in_item.rem[14:0], 1'b0};
            item_next.qovf = in_item.qovf | in_item.quo[15];
            item_next.quo = {in_item.quo[14:0], 1'b1};
        end else begin
            item_next.rem = {in_item.rem[30:0], 1'b0};
            item_next.qovf = in_item.qovf | in_item.quo[15];
            item_next.quo = {in_item.quo[14:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end
endmodule

// ===== src/double_word_alu_with_flags.sv =====
// Pipeline: 18 register stages (input stage, 16 divide steps, output register);
// one input transaction is accepted per cycle while the output is not stalled.
// The divider is a chain of 16 one-bit restoring stages, which sets latency.
// Stalls propagate back through per-stage valid bits; nothing is lost.
// Reset (aresetn low, synchronous) empties every stage.
// ----------------------------------------------------------------------------
// Double-word ALU with flags
// Add/subtract on a 32-bit pair, signed multiply of the low halves, signed 32/16 divide.
// ----------------------------------------------------------------------------
module double_word_alu_with_flags (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], reg_high_in[17:2], reg_low_in[33:18], flags_in[37:34],
    // arg_high[53:38], arg_low[69:54], zero fill to 72
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // reg_high_out[15:0], reg_low_out[31:16], flags_out[35:32],
    // status[37:36], zero fill to 40
    output logic [39:0] m_tdata
);
    localparam int NS = dwalu_pkg::DIV_STAGES;

    logic [1:0]  op;
    logic [15:0] hi, lo, bh, bl;
    logic [3:0]  fl;
    assign op = s_tdata[1:0];
    assign hi = s_tdata[17:2];
    assign lo = s_tdata[33:18];
    assign fl = s_tdata[37:34];
    assign bh = s_tdata[53:38];
    assign bl = s_tdata[69:54];

    // Stage 0: add/subtract and multiply, divide setup.
    logic             v0_reg;
    dwalu_pkg::item_t i0_reg, i0_next;
    logic [31:0]      acc, b, res, amag;
    logic [32:0]      sum;
    logic             ovf;
    logic signed [31:0] prod;

    always_comb begin
        acc = {hi, lo};
        b = (op == dwalu_pkg::OP_SUB) ? (32'd0 - {bh, bl}) : {bh, bl};
        sum = {1'b0, acc} + {1'b0, b};
        res = sum[31:0];
        ovf = (acc[31] == b[31]) && (res[31] != acc[31]);
        prod = $signed(lo) * $signed(bl);
        amag = acc[31] ? (32'd0 - acc) : acc;
        i0_next = '0;
        i0_next.opcode = op;
        i0_next.reg_high = hi;
        i0_next.reg_low = lo;
        i0_next.flags = fl;
        i0_next.res_flags = fl;
        if (op == dwalu_pkg::OP_MUL) begin
            i0_next.res_high = prod[31:16];
            i0_next.res_low = prod[15:0];
            i0_next.res_flags[dwalu_pkg::FLAG_Z] = (prod == 32'sd0);
            i0_next.res_flags[dwalu_pkg::FLAG_M] = prod[31];
        end else begin
            i0_next.res_high = res[31:16];
            i0_next.res_low = res[15:0];
            i0_next.res_flags[dwalu_pkg::FLAG_V] = fl[dwalu_pkg::FLAG_V] | ovf;
            i0_next.res_flags[dwalu_pkg::FLAG_Z] = (res == 32'd0);
            i0_next.res_flags[dwalu_pkg::FLAG_M] = res[31] ^ ovf;
            i0_next.res_flags[dwalu_pkg::FLAG_C] = sum[32];
        end
        i0_next.a_neg = acc[31];
        i0_next.d_neg = bl[15];
        i0_next.div0 = (bl == 16'd0);
        i0_next.rem = amag;
        i0_next.dmag = bl[15] ? (16'd0 - bl) : bl;
        // Magnitude of the most negative dividend needs 32 bits unsigned;
        // a set top bit alone already means the quotient cannot fit.
        i0_next.qovf = 1'b0;
    end

    logic             vst [NS+1];
    logic             rst [NS+1];
    dwalu_pkg::item_t ist [NS+1];

    assign s_tready = !v0_reg || rst[0];
    assign vst[0] = v0_reg;
    assign ist[0] = i0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_tready) begin
            v0_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            i0_reg <= i0_next;
        end
    end

    // The 32-bit unsigned dividend goes through 32 bits of quotient in
    // principle; stages produce the low 16 quotient bits after a 16-bit
    // pre-shift check: the high half must be below the divisor.
    for (genvar g = 0; g < NS; g++) begin : g_div
        dwalu_pkg::item_t stage_in;
        always_comb begin
            stage_in = ist[g];
            if (g == 0) begin
                stage_in.qovf = (ist[0].rem[31:16] >= ist[0].dmag);
            end
        end
        dwalu_div_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (vst[g]),
            .in_ready (rst[g]),
            .in_item  (stage_in),
            .out_valid(vst[g+1]),
            .out_ready(rst[g+1]),
            .out_item (ist[g+1])
        );
    end

    // Final stage: signs, range check and select.
    logic             vf_reg;
    logic [39:0]      df_reg, df_next;
    dwalu_pkg::item_t it;
    logic [15:0]      q, r;
    logic [15:0]      qmag;
    logic             qneg, bad;
    logic [3:0]       dfl;

    assign rst[NS] = !vf_reg || m_tready;

    always_comb begin
        it = ist[NS];
        qmag = it.quo;
        qneg = it.a_neg ^ it.d_neg;
        q = qneg ? (16'd0 - qmag) : qmag;
        r = it.a_neg ? (16'd0 - it.rem[31:16]) : it.rem[31:16];
        bad = it.qovf || (qneg ? (qmag > 16'h8000) : qmag[15]);
        dfl = it.flags;
        dfl[dwalu_pkg::FLAG_Z] = (q == 16'd0);
        dfl[dwalu_pkg::FLAG_M] = q[15];
        if (it.opcode != dwalu_pkg::OP_DIV) begin
            df_next = {2'd0, dwalu_pkg::ST_OK, it.res_flags, it.res_low, it.res_high};
        end else if (it.div0) begin
            df_next = {2'd0, dwalu_pkg::ST_DIV0, it.flags, it.reg_low, it.reg_high};
        end else if (bad) begin
            df_next = {2'd0, dwalu_pkg::ST_OVF, it.flags, it.reg_low, it.reg_high};
        end else begin
            df_next = {2'd0, dwalu_pkg::ST_OK, dfl, q, r};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (rst[NS]) begin
            vf_reg <= vst[NS];
        end
        if (rst[NS] && vst[NS]) begin
            df_reg <= df_next;
        end
    end

    assign m_tvalid = vf_reg;
    assign m_tdata  = df_reg;
endmodule
